// ----- hw/rtl/cmf_pkg.sv -----
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types and constants of the cross median filter: channel and pixel
// widths, register indexes, command codes and the five-point window.
// ----------------------------------------------------------------------------
package cmf_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int PIX_W       = CHAN_W * NUM_CHAN;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int WIDTH_CFG_W = 11;
   localparam int HEIGHT_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd2;

   localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd1;
   localparam logic                   COLOR_RESET  = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PIX_W-1:0]  pixel_type;

   typedef struct packed {
      chan_type up;
      chan_type left;
      chan_type center;
      chan_type right;
      chan_type down;
   } cross_type;

endpackage

// ----- hw/rtl/cmf_median_lane.sv -----
// ----------------------------------------------------------------------------
// cmf_median_lane
// Median of the five values of one channel's cross window, built as a
// fixed compare network.
// ----------------------------------------------------------------------------
module cmf_median_lane (
   input  cmf_pkg::cross_type win,
   output cmf_pkg::chan_type  median
);

   cmf_pkg::chan_type lo1, hi1, lo2, hi2;
   cmf_pkg::chan_type x_val, p_lo, p_hi, lo3, hi3;

   always_comb begin
      lo1 = (win.up < win.left) ? win.up : win.left;
      hi1 = (win.up < win.left) ? win.left : win.up;
      lo2 = (win.center < win.right) ? win.center : win.right;
      hi2 = (win.center < win.right) ? win.right : win.center;
      // drop the smallest of the four, it lies below the median
      if (lo1 < lo2) begin
         x_val = hi1;
         p_lo  = lo2;
         p_hi  = hi2;
      end else begin
         x_val = hi2;
         p_lo  = lo1;
         p_hi  = hi1;
      end
      lo3 = (x_val < win.down) ? x_val : win.down;
      hi3 = (x_val < win.down) ? win.down : x_val;
      if (p_lo < lo3) begin
         median = (lo3 < p_hi) ? lo3 : p_hi;
      end else begin
         median = (p_lo < hi3) ? p_lo : hi3;
      end
   end

endmodule

// ----- hw/rtl/cross_median_filter_in_place_unit.sv -----
// ----------------------------------------------------------------------------
// cross_median_filter_in_place_unit
// Streaming five-point cross median filter over raster pixels, in place.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, pixel or drain command, while the output
// is not stalled, and gives results through an output register; the rate is
// set by the two row stores, each read once per transaction (the raw row at
// the current and next column, the filtered row at the current column) with
// registered read data, and by the three channel lanes that finish a median
// in the stage after the read. Results lag the input by one image row: the
// first row gives no result, and after the last pixel the final row is
// emptied by one drain command per pixel, the last of which carries tlast
// and restarts the stream. Border pixels pass through unchanged; in gray mode
// only the first channel is output and the other two read as zero. Any
// register write restarts the stream. The row stores hold MAX_WIDTH pixels.
// ----------------------------------------------------------------------------
module cross_median_filter_in_place_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cmf_pkg::PIX_W-1:0]        req_tdata,   // chan_a, chan_b, chan_c
   input  logic                             req_tuser,   // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cmf_pkg::PIX_W-1:0]        rsp_tdata,   // res_a, res_b, res_c
   output logic                             rsp_tlast,   // last_pixel
   input  logic                             csr_we,
   input  logic [cmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cmf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int EXT_W = (CNT_W > cmf_pkg::WIDTH_CFG_W) ? CNT_W : cmf_pkg::WIDTH_CFG_W;

   // configuration
   logic [cmf_pkg::WIDTH_CFG_W-1:0] width_cfg_ff, width_cfg_in;
   logic [cmf_pkg::HEIGHT_W-1:0]    height_cfg_ff, height_cfg_in;
   logic                            color_ff, color_in;

   // stream position
   logic [COL_W-1:0]             col_ff, col_in;
   logic [cmf_pkg::HEIGHT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0]             pend_ff, pend_in;

   // row stores
   cmf_pkg::pixel_type held_row_ff [MAX_WIDTH];
   cmf_pkg::pixel_type far_row_ff  [MAX_WIDTH];

   // window stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_pixel_ff;
   logic               s1_interior_ff;
   logic               s1_last_ff;
   logic [COL_W-1:0]   s1_col_ff;
   cmf_pkg::pixel_type s1_down_ff;
   cmf_pkg::pixel_type s1_center_ff;
   cmf_pkg::pixel_type s1_right_ff;
   cmf_pkg::pixel_type s1_up_ff;
   cmf_pkg::pixel_type left_ff;

   // output register
   logic               out_valid_ff, out_valid_in;
   cmf_pkg::pixel_type out_data_ff;
   logic               out_last_ff;

   logic [CNT_W-1:0]             w_eff;
   logic [EXT_W-1:0]             width_ext;
   logic [cmf_pkg::HEIGHT_W-1:0] h_eff;
   logic [CNT_W-1:0]             col_inc;
   logic [COL_W-1:0]             col_right;
   logic [cmf_pkg::HEIGHT_W-1:0] row_inc;
   logic out_free, s1_free, s1_go, accept, is_drain, pend_nz;
   logic drain_last, pix_act, pix_emit, emit, interior, col_wrap, cfg_hit;

   cmf_pkg::cross_type lane_win [cmf_pkg::NUM_CHAN];
   cmf_pkg::chan_type  lane_med [cmf_pkg::NUM_CHAN];
   cmf_pkg::pixel_type merged;
   cmf_pkg::pixel_type masked;

   assign width_ext = EXT_W'(width_cfg_ff);

   always_comb begin
      if (width_cfg_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(width_ext);
      end
   end

   assign h_eff = (height_cfg_ff == '0) ? cmf_pkg::HEIGHT_W'(1) : height_cfg_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   assign is_drain   = (req_tuser == cmf_pkg::CMD_DRAIN);
   assign pend_nz    = (pend_ff != '0);
   assign drain_last = (pend_ff == CNT_W'(1));
   assign pix_act    = !is_drain && !pend_nz;
   assign pix_emit   = pix_act && (row_ff != '0);
   assign emit       = is_drain ? pend_nz : pix_emit;

   assign col_inc   = CNT_W'(col_ff) + CNT_W'(1);
   assign col_right = col_ff + COL_W'(1);
   assign col_wrap  = (col_inc == w_eff);
   assign row_inc   = row_ff + cmf_pkg::HEIGHT_W'(1);
   assign interior  = (row_ff >= cmf_pkg::HEIGHT_W'(2)) && (col_ff != '0) &&
                      (col_inc < w_eff);

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      color_in      = color_ff;
      cfg_hit       = 1'b0;
      col_in        = col_ff;
      row_in        = row_ff;
      pend_in       = pend_ff;
      if (csr_we) begin
         case (csr_index)
            cmf_pkg::CSR_IMAGE_WIDTH: begin
               width_cfg_in = csr_wdata[cmf_pkg::WIDTH_CFG_W-1:0];
               cfg_hit      = 1'b1;
            end
            cmf_pkg::CSR_IMAGE_HEIGHT: begin
               height_cfg_in = csr_wdata[cmf_pkg::HEIGHT_W-1:0];
               cfg_hit       = 1'b1;
            end
            cmf_pkg::CSR_COLOR_MODE: begin
               color_in = csr_wdata[0];
               cfg_hit  = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (cfg_hit) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (accept) begin
         if (is_drain) begin
            if (pend_nz) begin
               pend_in = pend_ff - CNT_W'(1);
               if (drain_last) begin
                  col_in = '0;
                  row_in = '0;
               end else begin
                  col_in = col_right;
               end
            end
         end else if (pix_act) begin
            if (col_wrap) begin
               col_in = '0;
               row_in = row_inc;
               if (row_inc >= h_eff) begin
                  pend_in = w_eff;
               end
            end else begin
               col_in = COL_W'(col_inc);
            end
         end
      end
   end

   assign s1_valid_in  = s1_free ? (accept && emit) : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= cmf_pkg::WIDTH_RESET;
         height_cfg_ff <= cmf_pkg::HEIGHT_RESET;
         color_ff      <= cmf_pkg::COLOR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         color_ff      <= color_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_ff       <= pend_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // raw row: read current and right neighbor, overwrite current with new pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_center_ff <= held_row_ff[col_ff];
         s1_right_ff  <= held_row_ff[col_right];
         if (pix_act) begin
            held_row_ff[col_ff] <= req_tdata;
         end
      end
   end

   // filtered row: read above, write back the filtered result
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_up_ff <= far_row_ff[col_ff];
      end
      if (s1_go && s1_pixel_ff) begin
         far_row_ff[s1_col_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= !is_drain;
         s1_interior_ff <= interior && !is_drain;
         s1_last_ff     <= is_drain && drain_last;
         s1_col_ff      <= col_ff;
         s1_down_ff     <= req_tdata;
      end
      if (s1_go) begin
         out_data_ff <= masked;
         out_last_ff <= s1_last_ff;
         if (s1_pixel_ff) begin
            left_ff <= merged;
         end
      end
   end

   for (genvar k = 0; k < cmf_pkg::NUM_CHAN; k++) begin : g_lane
      assign lane_win[k].up     = s1_up_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];
      assign lane_win[k].left   = left_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];
      assign lane_win[k].center = s1_center_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];
      assign lane_win[k].right  = s1_right_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];
      assign lane_win[k].down   = s1_down_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];

      cmf_median_lane u_lane (
         .win    (lane_win[k]),
         .median (lane_med[k])
      );
   end

   // merge lanes; border pixels and drains pass the held value
   always_comb begin
      for (int k = 0; k < cmf_pkg::NUM_CHAN; k++) begin
         merged[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W] =
            s1_interior_ff ? lane_med[k]
                           : s1_center_ff[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W];
      end
      masked = color_ff ? merged
                        : {{(cmf_pkg::PIX_W - cmf_pkg::CHAN_W){1'b0}},
                           merged[cmf_pkg::CHAN_W-1:0]};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(col_ff) < w_eff))
      else $error("column position beyond image width");

   a_drain_span: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |->
         (({1'b0, CNT_W'(col_ff)} + {1'b0, pend_ff}) == {1'b0, w_eff}))
      else $error("pending drain count out of step with column position");

   a_last_out: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (rsp_tvalid && rsp_tlast))
      else $error("final pixel did not reach the output register");

endmodule
